>>> src/dfwl_pkg.sv
package dfwl_pkg;

    // Frame layout
    localparam int TUNING_BITS  = 32;
    localparam int CONTROL_BITS = 8;
    localparam int FRAME_BITS   = TUNING_BITS + CONTROL_BITS;
    localparam int IDX_W        = 6;

    // Frequency limits and sweep position saturation
    localparam int             KHZ_W    = 16;
    localparam int             POS_W    = 17;
    localparam logic [POS_W-1:0] MAX_KHZ = 17'd40000;
    localparam logic [POS_W-1:0] POS_MAX = 17'h1FFFF;

    // Control bytes
    localparam logic [CONTROL_BITS-1:0] CTRL_RUN        = 8'h00;
    localparam logic [CONTROL_BITS-1:0] CTRL_POWER_DOWN = 8'h20;

    // Tuning word = f * 2^32 / 125000 = f * 34359 + floor(f * 11537 / 15625).
    // The fractional part is a reciprocal multiply: floor(x / 15625) equals
    // (x * 1125899907) >> 44 for every x below 2^30.
    localparam int                 X_W           = 30;
    localparam int                 RECIP_W       = 31;
    localparam int                 PROD_W        = X_W + RECIP_W + 1;
    localparam int                 RECIP_SHIFT   = 44;
    localparam logic [TUNING_BITS-1:0] WORD_INT_MUL  = 32'd34359;
    localparam logic [X_W-1:0]     WORD_FRAC_MUL = 30'd11537;
    localparam logic [PROD_W-1:0]  RECIP_MUL     = 62'd1125899907;

    // Command queue depth between front and back
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [2:0] {
        ACT_SET_FREQ    = 3'd0,
        ACT_POWER_DOWN  = 3'd1,
        ACT_RESET       = 3'd2,
        ACT_SWEEP_START = 3'd3,
        ACT_SWEEP_NEXT  = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        KIND_DATA       = 2'd0,
        KIND_RESET      = 2'd1,
        KIND_RANGE_ERR  = 2'd2,
        KIND_SWEEP_DONE = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        CFG_SWEEP_START = 2'd0,
        CFG_SWEEP_STOP  = 2'd1,
        CFG_SWEEP_STEP  = 2'd2
    } t_cfg_reg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_MUL,
        ST_SUM,
        ST_SHIFT,
        ST_SINGLE
    } t_back_state;

    // One classified command, as handed from front to back
    typedef struct packed {
        logic             frame;
        t_kind            kind;
        logic             power_down;
        logic [KHZ_W-1:0] khz;
        logic [KHZ_W-1:0] stored;
        logic             running;
    } t_job;

endpackage

>>> src/dfwl_front.sv
module dfwl_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [1:0]                   i_cfg_idx,
    input  logic [dfwl_pkg::KHZ_W-1:0]   i_cfg_data,
    input  logic                         i_push,
    input  logic [2:0]                   i_action,
    input  logic [dfwl_pkg::KHZ_W-1:0]   i_freq_khz,
    input  logic                         i_q_full,
    output logic                         o_q_push,
    output dfwl_pkg::t_job               o_job
);

    logic [dfwl_pkg::KHZ_W-1:0] r_start;
    logic [dfwl_pkg::KHZ_W-1:0] r_stop;
    logic [dfwl_pkg::KHZ_W-1:0] r_step;
    logic [dfwl_pkg::KHZ_W-1:0] r_current_khz;
    logic [dfwl_pkg::KHZ_W-1:0] n_current_khz;
    logic [dfwl_pkg::POS_W-1:0] r_sweep_pos;
    logic [dfwl_pkg::POS_W-1:0] n_sweep_pos;
    logic                       r_sweep_active;
    logic                       n_sweep_active;
    logic [dfwl_pkg::POS_W:0]   step_sum;
    logic                       accept;
    logic                       job_valid;
    logic                       use_point;
    dfwl_pkg::t_job             job;

    assign accept   = i_push & ~i_q_full;
    assign step_sum = {1'b0, r_sweep_pos} + {2'b0, r_step};

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
            r_stop  <= '0;
            r_step  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                dfwl_pkg::CFG_SWEEP_START: r_start <= i_cfg_data;
                dfwl_pkg::CFG_SWEEP_STOP:  r_stop  <= i_cfg_data;
                dfwl_pkg::CFG_SWEEP_STEP:  r_step  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Classify the command and work out the state it leaves
    always_comb begin
        n_current_khz  = r_current_khz;
        n_sweep_pos    = r_sweep_pos;
        n_sweep_active = r_sweep_active;
        job_valid      = 1'b0;
        use_point      = 1'b0;
        job.frame      = 1'b0;
        job.kind       = dfwl_pkg::KIND_DATA;
        job.power_down = 1'b0;
        job.khz        = '0;
        case (i_action)
            dfwl_pkg::ACT_SET_FREQ: begin
                job_valid = 1'b1;
                if ({1'b0, i_freq_khz} > dfwl_pkg::MAX_KHZ) begin
                    job.kind = dfwl_pkg::KIND_RANGE_ERR;
                end else begin
                    job.frame     = 1'b1;
                    job.khz       = i_freq_khz;
                    n_current_khz = i_freq_khz;
                end
            end
            dfwl_pkg::ACT_POWER_DOWN: begin
                job_valid      = 1'b1;
                job.frame      = 1'b1;
                job.power_down = 1'b1;
            end
            dfwl_pkg::ACT_RESET: begin
                job_valid = 1'b1;
                job.kind  = dfwl_pkg::KIND_RESET;
            end
            dfwl_pkg::ACT_SWEEP_START: begin
                job_valid      = 1'b1;
                n_sweep_pos    = {1'b0, r_start};
                n_sweep_active = 1'b1;
                use_point      = 1'b1;
            end
            dfwl_pkg::ACT_SWEEP_NEXT: begin
                job_valid = 1'b1;
                if (!r_sweep_active) begin
                    job.kind = dfwl_pkg::KIND_SWEEP_DONE;
                end else begin
                    // saturate at the top of the position range
                    n_sweep_pos = step_sum[dfwl_pkg::POS_W] ? dfwl_pkg::POS_MAX
                                                            : step_sum[dfwl_pkg::POS_W-1:0];
                    use_point   = 1'b1;
                end
            end
            default: ;
        endcase

        // Sweep point: past stop, out of range, or programmed
        if (use_point) begin
            if (n_sweep_pos > {1'b0, r_stop}) begin
                n_sweep_active = 1'b0;
                job.kind       = dfwl_pkg::KIND_SWEEP_DONE;
            end else if (n_sweep_pos > dfwl_pkg::MAX_KHZ) begin
                n_sweep_active = 1'b0;
                job.kind       = dfwl_pkg::KIND_RANGE_ERR;
            end else begin
                job.frame     = 1'b1;
                job.khz       = n_sweep_pos[dfwl_pkg::KHZ_W-1:0];
                n_current_khz = n_sweep_pos[dfwl_pkg::KHZ_W-1:0];
            end
        end
        job.stored  = n_current_khz;
        job.running = n_sweep_active;
    end

    // Loader state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_current_khz  <= '0;
            r_sweep_pos    <= '0;
            r_sweep_active <= 1'b0;
        end else if (accept) begin
            r_current_khz  <= n_current_khz;
            r_sweep_pos    <= n_sweep_pos;
            r_sweep_active <= n_sweep_active;
        end
    end

    assign o_q_push = accept & job_valid;
    assign o_job    = job;

endmodule

>>> src/dfwl_queue.sv
module dfwl_queue #(
    parameter int DEPTH = dfwl_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  dfwl_pkg::t_job i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output dfwl_pkg::t_job o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    dfwl_pkg::t_job r_mem [DEPTH];
    dfwl_pkg::t_job r_rd_data;
    logic [AW-1:0]  r_wr_ptr;
    logic [AW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_rd_data;

    // Storage; read data is registered on the pop and lands in the cycle after it
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
        if (i_pop) begin
            r_rd_data <= r_mem[r_rd_ptr];
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> src/dfwl_back.sv
module dfwl_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_empty,
    input  dfwl_pkg::t_job               i_q_data,
    output logic                         o_q_pop,
    input  logic                         i_pop,
    output logic                         o_empty,
    output logic [1:0]                   o_kind,
    output logic                         o_data_bit,
    output logic [dfwl_pkg::IDX_W-1:0]   o_bit_index,
    output logic                         o_latch,
    output logic                         o_last,
    output logic [dfwl_pkg::KHZ_W-1:0]   o_stored_freq,
    output logic                         o_sweep_running
);

    dfwl_pkg::t_back_state               r_state;
    dfwl_pkg::t_back_state               n_state;
    dfwl_pkg::t_job                      r_job;
    logic [dfwl_pkg::TUNING_BITS-1:0]    r_base;
    logic [dfwl_pkg::X_W-1:0]            r_x;
    logic [dfwl_pkg::PROD_W-1:0]         r_prod;
    logic [dfwl_pkg::FRAME_BITS-1:0]     r_shift;
    logic [dfwl_pkg::IDX_W-1:0]          r_idx;
    logic                                frame_end;
    logic                                out_free;
    logic                                load_out;

    logic                                r_out_valid;
    dfwl_pkg::t_kind                     r_kind;
    logic                                r_data_bit;
    logic [dfwl_pkg::IDX_W-1:0]          r_bit_index;
    logic                                r_latch;
    logic                                r_last;
    logic [dfwl_pkg::KHZ_W-1:0]          r_stored;
    logic                                r_running;

    assign out_free  = ~r_out_valid | i_pop;
    assign frame_end = (r_idx == dfwl_pkg::IDX_W'(dfwl_pkg::FRAME_BITS - 1));

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dfwl_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state, queue pop and result load
    always_comb begin
        n_state  = r_state;
        o_q_pop  = 1'b0;
        load_out = 1'b0;
        case (r_state)
            dfwl_pkg::ST_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_state = dfwl_pkg::ST_FETCH;
                end
            end
            dfwl_pkg::ST_FETCH: begin
                n_state = i_q_data.frame ? dfwl_pkg::ST_MUL : dfwl_pkg::ST_SINGLE;
            end
            dfwl_pkg::ST_MUL: begin
                n_state = dfwl_pkg::ST_SUM;
            end
            dfwl_pkg::ST_SUM: begin
                n_state = dfwl_pkg::ST_SHIFT;
            end
            dfwl_pkg::ST_SHIFT: begin
                if (out_free) begin
                    load_out = 1'b1;
                    if (frame_end) begin
                        n_state = dfwl_pkg::ST_IDLE;
                    end
                end
            end
            dfwl_pkg::ST_SINGLE: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = dfwl_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = dfwl_pkg::ST_IDLE;
            end
        endcase
    end

    // Tuning word datapath and frame shifter
    always_ff @(posedge i_clk) begin
        case (r_state)
            dfwl_pkg::ST_FETCH: begin
                r_job  <= i_q_data;
                r_base <= dfwl_pkg::TUNING_BITS'(i_q_data.khz) * dfwl_pkg::WORD_INT_MUL;
                r_x    <= dfwl_pkg::X_W'(i_q_data.khz) * dfwl_pkg::WORD_FRAC_MUL;
            end
            dfwl_pkg::ST_MUL: begin
                r_prod <= dfwl_pkg::PROD_W'(r_x) * dfwl_pkg::RECIP_MUL;
            end
            dfwl_pkg::ST_SUM: begin
                r_shift <= {(r_job.power_down ? dfwl_pkg::CTRL_POWER_DOWN : dfwl_pkg::CTRL_RUN),
                            r_base + dfwl_pkg::TUNING_BITS'(
                                r_prod[dfwl_pkg::PROD_W-1:dfwl_pkg::RECIP_SHIFT])};
                r_idx   <= '0;
            end
            dfwl_pkg::ST_SHIFT: begin
                if (out_free) begin
                    r_shift <= r_shift >> 1;
                    r_idx   <= r_idx + dfwl_pkg::IDX_W'(1);
                end
            end
            default: ;
        endcase
    end

    // Result register: holds the oldest result until transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_stored  <= r_job.stored;
            r_running <= r_job.running;
            if (r_state == dfwl_pkg::ST_SHIFT) begin
                r_kind      <= dfwl_pkg::KIND_DATA;
                r_data_bit  <= r_shift[0];
                r_bit_index <= r_idx;
                r_latch     <= frame_end;
                r_last      <= frame_end;
            end else begin
                r_kind      <= r_job.kind;
                r_data_bit  <= 1'b0;
                r_bit_index <= '0;
                r_latch     <= (r_job.kind == dfwl_pkg::KIND_RESET);
                r_last      <= 1'b1;
            end
        end
    end

    assign o_empty         = ~r_out_valid;
    assign o_kind          = r_kind;
    assign o_data_bit      = r_data_bit;
    assign o_bit_index     = r_bit_index;
    assign o_latch         = r_latch;
    assign o_last          = r_last;
    assign o_stored_freq   = r_stored;
    assign o_sweep_running = r_running;

endmodule

>>> src/dds_frequency_word_loader_top.sv
// Channel   Direction  Handshake             Fields
// command   in         push / full           i_action, i_freq_khz
// result    out        empty / pop           o_kind .. o_sweep_running
// config    in         i_cfg_we (no wait)    i_cfg_idx, i_cfg_data
//
// A frame command occupies the back end for the dequeue, the tuning word (two short
// multiplies, the reciprocal multiply, the sum), then one bit per cycle for 40 bits while
// the result register has room. Single-result commands take a dequeue, a fetch and
// one result. The front takes a command every cycle while
// the command queue (QUEUE_DEPTH entries) has room; a stalled pop holds the shifter.
// Reset is synchronous, active low, and clears loader state, registers and queue.
module dds_frequency_word_loader_top #(
    parameter int QUEUE_DEPTH = dfwl_pkg::QUEUE_DEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [1:0]                   i_cfg_idx,
    input  logic [dfwl_pkg::KHZ_W-1:0]   i_cfg_data,
    input  logic                         push,
    output logic                         full,
    input  logic [2:0]                   i_action,
    input  logic [dfwl_pkg::KHZ_W-1:0]   i_freq_khz,
    output logic                         empty,
    input  logic                         pop,
    output logic [1:0]                   o_kind,
    output logic                         o_data_bit,
    output logic [dfwl_pkg::IDX_W-1:0]   o_bit_index,
    output logic                         o_latch,
    output logic                         o_last,
    output logic [dfwl_pkg::KHZ_W-1:0]   o_stored_freq,
    output logic                         o_sweep_running
);

    logic           q_push;
    logic           q_full;
    logic           q_pop;
    logic           q_empty;
    dfwl_pkg::t_job q_in;
    dfwl_pkg::t_job q_out;

    assign full = q_full;

    // Command classification and loader state
    dfwl_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_push     (push),
        .i_action   (i_action),
        .i_freq_khz (i_freq_khz),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_job      (q_in)
    );

    // Job queue between front and back
    dfwl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_out)
    );

    // Tuning word and serial frame generation
    dfwl_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_empty       (q_empty),
        .i_q_data        (q_out),
        .o_q_pop         (q_pop),
        .i_pop           (pop),
        .o_empty         (empty),
        .o_kind          (o_kind),
        .o_data_bit      (o_data_bit),
        .o_bit_index     (o_bit_index),
        .o_latch         (o_latch),
        .o_last          (o_last),
        .o_stored_freq   (o_stored_freq),
        .o_sweep_running (o_sweep_running)
    );

    // Never write into a full job queue
    a_queue_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("job written into full queue");

    // Non-data results are lone, zero-index results
    a_single_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind != dfwl_pkg::KIND_DATA) |->
            (o_last && o_bit_index == '0 && !o_data_bit))
        else $error("malformed single result");

    // Only the power-down control bit can be set in the control byte
    a_control_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind == dfwl_pkg::KIND_DATA && o_data_bit &&
         o_bit_index >= dfwl_pkg::IDX_W'(dfwl_pkg::TUNING_BITS)) |->
            (o_bit_index == dfwl_pkg::IDX_W'(dfwl_pkg::TUNING_BITS + 5)))
        else $error("unexpected control bit set");

    // Stored frequency is always an in-range programmed value
    a_stored_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> ({1'b0, o_stored_freq} <= dfwl_pkg::MAX_KHZ))
        else $error("stored frequency out of range");

endmodule

>>> tb/dfwl_serial_checker.sv
`timescale 1ns / 100ps

// Watches the command, config and result channels of the frequency word loader,
// keeps its own copy of the loader state and compares every popped result.
module dfwl_serial_checker
    import dfwl_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [KHZ_W-1:0] i_cfg_data,
    input  logic             push,
    input  logic             full,
    input  logic [2:0]       i_action,
    input  logic [KHZ_W-1:0] i_freq_khz,
    input  logic             empty,
    input  logic             pop,
    input  logic [1:0]       i_kind,
    input  logic             i_data_bit,
    input  logic [IDX_W-1:0] i_bit_index,
    input  logic             i_latch,
    input  logic             i_last,
    input  logic [KHZ_W-1:0] i_stored_freq,
    input  logic             i_sweep_running,
    output int               o_errors,
    output int               o_waiting
);

    localparam longint unsigned REF_CLK_KHZ = 64'd125000;
    localparam int              MAX_REPORTS = 10;

    typedef struct {
        t_kind            kind;
        logic             data_bit;
        logic [IDX_W-1:0] bit_index;
        logic             latch;
        logic             last;
        logic [KHZ_W-1:0] stored_khz;
        logic             running;
    } t_pin_event;

    t_pin_event pin_events_q[$];
    int         mismatch_count = 0;

    // Mirror of the sweep registers
    logic [KHZ_W-1:0] sweep_start_khz = '0;
    logic [KHZ_W-1:0] sweep_stop_khz  = '0;
    logic [KHZ_W-1:0] sweep_step_khz  = '0;

    // Mirror of the loader state
    logic [KHZ_W-1:0] cur_khz   = '0;
    logic [POS_W-1:0] sweep_pos = '0;
    logic             sweep_on  = 1'b0;

    // Queue one serial interface event, tagged with the state after the command
    function automatic void note_event(t_kind k, logic b, logic [IDX_W-1:0] idx,
                                       logic strobe, logic final_one);
        t_pin_event ev;
        ev.kind       = k;
        ev.data_bit   = b;
        ev.bit_index  = idx;
        ev.latch      = strobe;
        ev.last       = final_one;
        ev.stored_khz = cur_khz;
        ev.running    = sweep_on;
        pin_events_q.push_back(ev);
    endfunction

    // 40 bit frame, LSB first: tuning word then control byte, latch on the final bit
    function automatic void shift_frame(logic [TUNING_BITS-1:0] word,
                                        logic [CONTROL_BITS-1:0] ctrl);
        logic [FRAME_BITS-1:0] frame;
        frame = {ctrl, word};
        for (int i = 0; i < FRAME_BITS; i++) begin
            note_event(KIND_DATA, frame[i], IDX_W'(i), i == FRAME_BITS - 1,
                       i == FRAME_BITS - 1);
        end
    endfunction

    function automatic void program_khz(logic [POS_W-1:0] khz);
        logic [TUNING_BITS-1:0] word;
        word = TUNING_BITS'((64'(khz) << TUNING_BITS) / REF_CLK_KHZ);
        cur_khz = khz[KHZ_W-1:0];
        shift_frame(word, CTRL_RUN);
    endfunction

    // Past the stop gives done, past the synthesiser limit gives a range error
    function automatic void sweep_point();
        if (sweep_pos > POS_W'(sweep_stop_khz)) begin
            sweep_on = 1'b0;
            note_event(KIND_SWEEP_DONE, 1'b0, '0, 1'b0, 1'b1);
        end else if (sweep_pos > MAX_KHZ) begin
            sweep_on = 1'b0;
            note_event(KIND_RANGE_ERR, 1'b0, '0, 1'b0, 1'b1);
        end else begin
            program_khz(sweep_pos);
        end
    endfunction

    // Expected serial events for one accepted command
    function automatic void load_dds_command(logic [2:0] act, logic [KHZ_W-1:0] khz);
        logic [POS_W:0] next_pos;
        case (act)
            ACT_SET_FREQ: begin
                if (POS_W'(khz) > MAX_KHZ) begin
                    note_event(KIND_RANGE_ERR, 1'b0, '0, 1'b0, 1'b1);
                end else begin
                    program_khz(POS_W'(khz));
                end
            end
            ACT_POWER_DOWN: shift_frame('0, CTRL_POWER_DOWN);
            ACT_RESET:      note_event(KIND_RESET, 1'b0, '0, 1'b1, 1'b1);
            ACT_SWEEP_START: begin
                sweep_pos = POS_W'(sweep_start_khz);
                sweep_on  = 1'b1;
                sweep_point();
            end
            ACT_SWEEP_NEXT: begin
                if (!sweep_on) begin
                    note_event(KIND_SWEEP_DONE, 1'b0, '0, 1'b0, 1'b1);
                end else begin
                    next_pos  = (POS_W + 1)'(sweep_pos) + (POS_W + 1)'(sweep_step_khz);
                    sweep_pos = (next_pos > (POS_W + 1)'(POS_MAX)) ? POS_MAX
                                                                   : next_pos[POS_W-1:0];
                    sweep_point();
                end
            end
            default: ;  // unused codes are dropped
        endcase
    endfunction

    // Compare one popped result against the oldest expectation
    function automatic void check_pin_event();
        t_pin_event ev;
        if (pin_events_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("%0t: unexpected result kind=%0d bit=%0d idx=%0d", $realtime,
                         i_kind, i_data_bit, i_bit_index);
            return;
        end
        ev = pin_events_q.pop_front();
        if (i_kind !== ev.kind || i_data_bit !== ev.data_bit ||
            i_bit_index !== ev.bit_index || i_latch !== ev.latch ||
            i_last !== ev.last || i_stored_freq !== ev.stored_khz ||
            i_sweep_running !== ev.running) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
                $display("%0t: mismatch exp kind=%0d bit=%0d idx=%0d latch=%0d last=%0d",
                         $realtime, ev.kind, ev.data_bit, ev.bit_index, ev.latch, ev.last,
                         " stored=%0d run=%0d", ev.stored_khz, ev.running);
                $display("%0t:          got kind=%0d bit=%0d idx=%0d latch=%0d last=%0d",
                         $realtime, i_kind, i_data_bit, i_bit_index, i_latch, i_last,
                         " stored=%0d run=%0d", i_stored_freq, i_sweep_running);
            end
        end
    endfunction

    // Sample all channels at the clock edge; counts go out registered
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SWEEP_START: sweep_start_khz = i_cfg_data;
                    CFG_SWEEP_STOP:  sweep_stop_khz  = i_cfg_data;
                    CFG_SWEEP_STEP:  sweep_step_khz  = i_cfg_data;
                    default: ;
                endcase
            end
            if (pop && !empty)
                check_pin_event();
            if (push && !full)
                load_dds_command(i_action, i_freq_khz);
        end
        o_waiting <= pin_events_q.size();
        o_errors  <= mismatch_count;
    end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the frequency word loader; checking lives in the checker.
module tb_top;
    import dfwl_pkg::*;

    localparam int         RUN_ITEMS      = 350;  // directed plus about 330 random
    localparam int         PHASE_ITEMS    = 55;
    localparam int         SETTLE_CYCLES  = 60;   // longer than one frame in the back end
    localparam int         ACT_CODES      = 8;
    localparam logic [1:0] CFG_UNUSED_IDX = 2'd3;

    logic             i_clk;
    logic             i_rst_n    = 1'b0;
    logic             i_cfg_we   = 1'b0;
    logic [1:0]       i_cfg_idx  = CFG_SWEEP_START;
    logic [KHZ_W-1:0] i_cfg_data = '0;
    logic             push       = 1'b0;
    logic [2:0]       i_action   = ACT_SET_FREQ;
    logic [KHZ_W-1:0] i_freq_khz = '0;
    logic             pop        = 1'b0;
    logic             full;
    logic             empty;
    logic [1:0]       o_kind;
    logic             o_data_bit;
    logic [IDX_W-1:0] o_bit_index;
    logic             o_latch;
    logic             o_last;
    logic [KHZ_W-1:0] o_stored_freq;
    logic             o_sweep_running;
    int               errors;
    int               waiting;

    int burst_left    = 1;
    int counted_items = 0;

    dds_frequency_word_loader_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .push            (push),
        .full            (full),
        .i_action        (i_action),
        .i_freq_khz      (i_freq_khz),
        .empty           (empty),
        .pop             (pop),
        .o_kind          (o_kind),
        .o_data_bit      (o_data_bit),
        .o_bit_index     (o_bit_index),
        .o_latch         (o_latch),
        .o_last          (o_last),
        .o_stored_freq   (o_stored_freq),
        .o_sweep_running (o_sweep_running)
    );

    dfwl_serial_checker i_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .push            (push),
        .full            (full),
        .i_action        (i_action),
        .i_freq_khz      (i_freq_khz),
        .empty           (empty),
        .pop             (pop),
        .i_kind          (o_kind),
        .i_data_bit      (o_data_bit),
        .i_bit_index     (o_bit_index),
        .i_latch         (o_latch),
        .i_last          (o_last),
        .i_stored_freq   (o_stored_freq),
        .i_sweep_running (o_sweep_running),
        .o_errors        (errors),
        .o_waiting       (waiting)
    );

    // 100 MHz clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Receiver: switches between free running, coin toss, heavy stall and 3-in-4
    int pop_mode      = 0;
    int pop_mode_left = 0;
    int pop_tick      = 0;

    always @(posedge i_clk) begin
        pop_tick <= pop_tick + 1;
        if (pop_mode_left == 0) begin
            pop_mode      <= $urandom_range(0, 3);
            pop_mode_left <= $urandom_range(20, 200);
        end else begin
            pop_mode_left <= pop_mode_left - 1;
        end
        case (pop_mode)
            0:       pop <= 1'b1;
            1:       pop <= ($urandom_range(0, 1) == 1);
            2:       pop <= ($urandom_range(0, 7) == 0);
            default: pop <= (pop_tick[1:0] != 2'b11);
        endcase
    end

    // One command transfer; bursts of back-to-back items, random gaps between bursts
    task automatic issue(input logic [2:0] act, input logic [KHZ_W-1:0] khz);
        int gap;
        i_action   <= act;
        i_freq_khz <= khz;
        push       <= 1'b1;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        if (act <= ACT_SWEEP_NEXT)
            counted_items++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 8);
            gap        = $urandom_range(0, 12);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Hold off until every expected result is out, then let the back end settle
    task automatic drain_results();
        push <= 1'b0;
        @(posedge i_clk);
        while (waiting != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Only called with the loader idle; the unused index must have no effect
    task automatic write_sweep_regs(input logic [KHZ_W-1:0] start_khz,
                                    input logic [KHZ_W-1:0] stop_khz,
                                    input logic [KHZ_W-1:0] step_khz);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_SWEEP_START;
        i_cfg_data <= start_khz;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_SWEEP_STOP;
        i_cfg_data <= stop_khz;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_SWEEP_STEP;
        i_cfg_data <= step_khz;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_UNUSED_IDX;
        i_cfg_data <= KHZ_W'($urandom_range(0, 65535));
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Mostly legal frequencies, with the limit edges and the full field mixed in
    function automatic logic [KHZ_W-1:0] pick_khz();
        int sel;
        sel = $urandom_range(0, 15);
        case (sel)
            0:       return '0;
            1:       return KHZ_W'(MAX_KHZ);
            2:       return KHZ_W'(MAX_KHZ + 1);
            3:       return '1;
            4, 5:    return KHZ_W'($urandom_range(0, 65535));
            default: return KHZ_W'($urandom_range(0, 40000));
        endcase
    endfunction

    // Stimulus
    initial begin
        int               phase_items;
        int               sel;
        int               run_len;
        logic [KHZ_W-1:0] start_khz;
        logic [KHZ_W-1:0] stop_khz;
        logic [KHZ_W-1:0] step_khz;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: field edges, every command, idle sweep next, zero step, unused codes
        issue(ACT_RESET, '0);
        issue(ACT_SET_FREQ, '0);
        issue(ACT_SET_FREQ, KHZ_W'(MAX_KHZ));
        issue(ACT_SET_FREQ, KHZ_W'(MAX_KHZ + 1));
        issue(ACT_SET_FREQ, '1);
        issue(ACT_SET_FREQ, 16'h5555);
        issue(ACT_POWER_DOWN, '1);
        issue(ACT_SWEEP_NEXT, '0);
        issue(ACT_SWEEP_START, '0);
        issue(ACT_SWEEP_NEXT, '1);
        for (int code = ACT_SWEEP_NEXT + 1; code < ACT_CODES; code++)
            issue(3'(code), KHZ_W'($urandom_range(0, 65535)));

        // Sweep runs into the range limit, then next on an ended sweep
        drain_results();
        write_sweep_regs(16'd39990, '1, 16'd7);
        issue(ACT_SWEEP_START, '0);
        repeat (3) issue(ACT_SWEEP_NEXT, '0);

        // Maximum step overshoots the stop at once
        drain_results();
        write_sweep_regs(16'd100, 16'd120, '1);
        issue(ACT_SWEEP_START, '0);
        issue(ACT_SWEEP_NEXT, '0);

        // Start at the top of the field: range error, then start above stop
        drain_results();
        write_sweep_regs('1, '1, '1);
        issue(ACT_SWEEP_START, '1);
        drain_results();
        write_sweep_regs('1, '0, 16'd1);
        issue(ACT_SWEEP_START, '0);

        // Random phases, each under a fresh sweep setting
        while (counted_items < RUN_ITEMS) begin
            drain_results();
            if ($urandom_range(0, 5) == 0) begin
                start_khz = KHZ_W'($urandom_range(0, 65535));
                stop_khz  = KHZ_W'($urandom_range(0, 65535));
                step_khz  = KHZ_W'($urandom_range(0, 65535));
            end else begin
                start_khz = KHZ_W'($urandom_range(0, 40000));
                stop_khz  = ($urandom_range(0, 7) == 0) ? '1 :
                            KHZ_W'((int'(start_khz) + $urandom_range(0, 2000)));
                step_khz  = ($urandom_range(0, 7) == 0) ? '0 :
                            KHZ_W'($urandom_range(1, 600));
            end
            write_sweep_regs(start_khz, stop_khz, step_khz);

            phase_items = counted_items;
            while (counted_items - phase_items < PHASE_ITEMS && counted_items < RUN_ITEMS) begin
                sel = $urandom_range(0, 9);
                if (sel < 5) begin
                    // well-formed sweep: start, then a run of next points
                    issue(ACT_SWEEP_START, KHZ_W'($urandom_range(0, 65535)));
                    run_len = $urandom_range(1, 8);
                    repeat (run_len) issue(ACT_SWEEP_NEXT, KHZ_W'($urandom_range(0, 65535)));
                end else if (sel < 8) begin
                    issue(ACT_SET_FREQ, pick_khz());
                end else if (sel == 8) begin
                    issue(($urandom_range(0, 1) == 1) ? ACT_POWER_DOWN : ACT_RESET,
                          KHZ_W'($urandom_range(0, 65535)));
                end else begin
                    // noise: any code, unused ones included
                    issue(3'($urandom_range(0, ACT_CODES - 1)), KHZ_W'($urandom_range(0, 65535)));
                end
                if ($urandom_range(0, 39) == 0)
                    drain_results();
            end
        end

        drain_results();
        if (errors == 0 && waiting == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #6000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
